[rtl/brp_pkg.sv]
// ----------------------------------------------------------------------------
// Byte range parser package
// Shared payload types, result status codes and character constants for the
// single byte-range header parser.
// ----------------------------------------------------------------------------
package brp_pkg;

  localparam int SIZE_W               = 48;
  localparam int NUMBER_WIDTH_DEFAULT = 48;

  localparam logic [1:0] STATUS_NONE  = 2'd0;
  localparam logic [1:0] STATUS_VALID = 2'd1;
  localparam logic [1:0] STATUS_UNSAT = 2'd2;

  localparam logic [1:0] PHASE_PREFIX = 2'd0;
  localparam logic [1:0] PHASE_FIRST  = 2'd1;
  localparam logic [1:0] PHASE_SECOND = 2'd2;

  localparam logic [2:0] PREFIX_LAST  = 3'd5;

  localparam logic [7:0] DASH_CHAR    = 8'h2d;
  localparam logic [7:0] DIGIT_ZERO   = 8'h30;
  localparam logic [7:0] DIGIT_NINE   = 8'h39;

  typedef struct packed {
    logic [7:0]        header_byte;
    logic              has_byte;
    logic              last_byte;
    logic [SIZE_W-1:0] file_length;
  } brp_in_t;

  typedef struct packed {
    logic [1:0]        range_status;
    logic [SIZE_W-1:0] first_offset;
    logic [SIZE_W-1:0] final_offset;
  } brp_out_t;

  // Parse summary handed from the scanner to the range resolver.
  typedef struct packed {
    logic any_byte_seen;
    logic parse_failed;
    logic dash_seen;
    logic first_digits_seen;
    logic second_digits_seen;
  } brp_flags_t;

  // Expected character of the "bytes=" prefix at each position.
  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h62;
      3'd1:    ch = 8'h79;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h65;
      3'd4:    ch = 8'h73;
      3'd5:    ch = 8'h3d;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

[rtl/brp_scan.sv]
// ----------------------------------------------------------------------------
// Byte range scanner
// Walks the header one character per transfer: prefix match, then two decimal
// accumulators split by the dash. Captures a summary when the last item passes.
// ----------------------------------------------------------------------------
module brp_scan #(
  parameter int NUMBER_WIDTH = brp_pkg::NUMBER_WIDTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  brp_pkg::brp_in_t            item,
  output brp_pkg::brp_flags_t         summary,
  output logic [NUMBER_WIDTH-1:0]     first_value,
  output logic [NUMBER_WIDTH-1:0]     second_value,
  output logic [brp_pkg::SIZE_W-1:0]  size_value
);
  import brp_pkg::*;

  localparam int AW = NUMBER_WIDTH + 4;

  logic [1:0]              phase, phase_next;
  logic [2:0]              prefix_count, prefix_count_next;
  logic [NUMBER_WIDTH-1:0] first_number, first_number_next;
  logic [NUMBER_WIDTH-1:0] second_number, second_number_next;
  logic                    first_seen, first_seen_next;
  logic                    second_seen, second_seen_next;
  logic                    any_seen, any_seen_next;
  logic                    failed, failed_next;

  logic                    is_digit;
  logic [3:0]              digit;
  logic [NUMBER_WIDTH-1:0] acc;
  logic [AW-1:0]           acc_scaled;
  logic                    acc_ovf;

  always_comb begin
    is_digit   = (item.header_byte >= DIGIT_ZERO) && (item.header_byte <= DIGIT_NINE);
    digit      = item.header_byte[3:0];
    acc        = (phase == PHASE_FIRST) ? first_number : second_number;
    // acc * 10 + digit as two shifted copies; anything above the number width
    // means the value no longer fits.
    acc_scaled = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
               + {{NUMBER_WIDTH{1'b0}}, digit};
    acc_ovf    = |acc_scaled[AW-1:NUMBER_WIDTH];

    phase_next         = phase;
    prefix_count_next  = prefix_count;
    first_number_next  = first_number;
    second_number_next = second_number;
    first_seen_next    = first_seen;
    second_seen_next   = second_seen;
    any_seen_next      = any_seen | item.has_byte;
    failed_next        = failed;

    if (item.has_byte && !failed) begin
      if (phase == PHASE_PREFIX) begin
        if (item.header_byte == prefix_char(prefix_count)) begin
          prefix_count_next = prefix_count + 3'd1;
          if (prefix_count == PREFIX_LAST) begin
            phase_next = PHASE_FIRST;
          end
        end else begin
          failed_next = 1'b1;
        end
      end else if (is_digit) begin
        if (phase == PHASE_FIRST) begin
          first_number_next = acc_scaled[NUMBER_WIDTH-1:0];
          first_seen_next   = 1'b1;
        end else begin
          second_number_next = acc_scaled[NUMBER_WIDTH-1:0];
          second_seen_next   = 1'b1;
        end
        if (acc_ovf) begin
          failed_next = 1'b1;
        end
      end else if ((item.header_byte == DASH_CHAR) && (phase == PHASE_FIRST)) begin
        phase_next = PHASE_SECOND;
      end else begin
        failed_next = 1'b1;
      end
    end
  end

  // Parse state returns to its cleared values once the last item has passed.
  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      phase         <= PHASE_PREFIX;
      prefix_count  <= '0;
      first_number  <= '0;
      second_number <= '0;
      first_seen    <= 1'b0;
      second_seen   <= 1'b0;
      any_seen      <= 1'b0;
      failed        <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      prefix_count  <= prefix_count_next;
      first_number  <= first_number_next;
      second_number <= second_number_next;
      first_seen    <= first_seen_next;
      second_seen   <= second_seen_next;
      any_seen      <= any_seen_next;
      failed        <= failed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && item.last_byte) begin
      summary.any_byte_seen      <= any_seen_next;
      summary.parse_failed       <= failed_next;
      summary.dash_seen          <= (phase_next == PHASE_SECOND);
      summary.first_digits_seen  <= first_seen_next;
      summary.second_digits_seen <= second_seen_next;
      first_value                <= first_number_next;
      second_value               <= second_number_next;
      size_value                 <= item.file_length;
    end
  end

endmodule

[rtl/brp_range.sv]
// ----------------------------------------------------------------------------
// Byte range resolver
// Turns a parse summary and the file size into a status and an inclusive
// byte range, clamping the end to the last byte of the file.
// ----------------------------------------------------------------------------
module brp_range #(
  parameter int NUMBER_WIDTH = brp_pkg::NUMBER_WIDTH_DEFAULT
) (
  input  brp_pkg::brp_flags_t         summary,
  input  logic [NUMBER_WIDTH-1:0]     first_value,
  input  logic [NUMBER_WIDTH-1:0]     second_value,
  input  logic [brp_pkg::SIZE_W-1:0]  size_value,
  output brp_pkg::brp_out_t           outcome
);
  import brp_pkg::*;

  localparam int CW = (NUMBER_WIDTH > SIZE_W) ? NUMBER_WIDTH : SIZE_W;

  logic [CW-1:0]     first_ext, second_ext, size_ext;
  logic [CW:0]       second_plus_one;
  logic [SIZE_W-1:0] size_minus_one, suffix_start;
  logic              first_below_size, second_below_size, second_not_below_first;
  logic              second_below_last, second_nonzero, size_zero;

  always_comb begin
    first_ext       = CW'(first_value);
    second_ext      = CW'(second_value);
    size_ext        = CW'(size_value);
    second_plus_one = {1'b0, second_ext} + {{CW{1'b0}}, 1'b1};

    size_zero              = (size_value == '0);
    second_nonzero         = (second_value != '0);
    first_below_size       = first_ext < size_ext;
    second_below_size      = second_ext < size_ext;
    second_not_below_first = second_ext >= first_ext;
    // second < size - 1 without waiting for the decrement
    second_below_last      = second_plus_one < {1'b0, size_ext};
    size_minus_one         = size_value - SIZE_W'(1);
    // A suffix longer than the file covers the whole file.
    suffix_start           = second_below_size ? (size_value - second_ext[SIZE_W-1:0])
                                               : '0;

    outcome.range_status = STATUS_UNSAT;
    outcome.first_offset = '0;
    outcome.final_offset = '0;

    priority if (!summary.any_byte_seen) begin
      outcome.range_status = STATUS_NONE;
    end else if (summary.parse_failed || !summary.dash_seen || size_zero) begin
      outcome.range_status = STATUS_UNSAT;
    end else if (!summary.first_digits_seen) begin
      if (summary.second_digits_seen && second_nonzero) begin
        outcome.range_status = STATUS_VALID;
        outcome.first_offset = suffix_start;
        outcome.final_offset = size_minus_one;
      end
    end else if (first_below_size) begin
      if (!summary.second_digits_seen) begin
        outcome.range_status = STATUS_VALID;
        outcome.first_offset = first_ext[SIZE_W-1:0];
        outcome.final_offset = size_minus_one;
      end else if (second_not_below_first) begin
        outcome.range_status = STATUS_VALID;
        outcome.first_offset = first_ext[SIZE_W-1:0];
        outcome.final_offset = second_below_last ? second_ext[SIZE_W-1:0]
                                                 : size_minus_one;
      end
    end else begin
      // A start at or past the end of the file cannot be served.
      outcome.range_status = STATUS_UNSAT;
    end
  end

endmodule

[rtl/http_byte_range_parser_unit.sv]
// ----------------------------------------------------------------------------
// HTTP single byte-range parser
// Parses a Range header value of the form bytes=A-B, bytes=A- or bytes=-N,
// one character per transfer, and gives one range result per header.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel carries one header character per transfer, with has_byte
//   low for an item that carries no character and last_byte high on the final
//   item, which also carries the file size. The result channel carries one
//   status and inclusive range for each item with last_byte set; other items
//   produce nothing.
//   Throughput is one item per cycle while no last item waits for room. A result
//   is offered once its last item has passed from the input register into the
//   scan summary register and from there into the result register.
//   Reset clears the pipeline valids and the parse state, so the first item
//   after reset starts a new header.
//   When the receiver stalls, the result register holds its transfer and the
//   summary register can hold one more finished header; characters that are
//   not last keep flowing, and only a last item waits for room.
// ----------------------------------------------------------------------------
module http_byte_range_parser_unit #(
  parameter int NUMBER_WIDTH = brp_pkg::NUMBER_WIDTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  brp_pkg::brp_in_t  item,
  output logic              result_valid,
  input  logic              result_ready,
  output brp_pkg::brp_out_t result
);
  import brp_pkg::*;

  logic                    stage_valid;
  brp_in_t                 stage_item;
  logic                    stage_step;

  logic                    summary_valid;
  logic                    summary_free;
  logic                    result_load;
  brp_flags_t              summary;
  logic [NUMBER_WIDTH-1:0] first_value, second_value;
  logic [SIZE_W-1:0]       size_value;
  brp_out_t                outcome;

  assign result_load  = summary_valid && (!result_valid || result_ready);
  assign summary_free = !summary_valid || result_load;
  assign stage_step   = stage_valid && (!stage_item.last_byte || summary_free);
  assign item_ready   = !stage_valid || stage_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stage_item <= item;
    end
  end

  brp_scan #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .step         (stage_step),
    .item         (stage_item),
    .summary      (summary),
    .first_value  (first_value),
    .second_value (second_value),
    .size_value   (size_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      summary_valid <= 1'b0;
    end else if (stage_step && stage_item.last_byte) begin
      summary_valid <= 1'b1;
    end else if (result_load) begin
      summary_valid <= 1'b0;
    end
  end

  brp_range #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_range (
    .summary      (summary),
    .first_value  (first_value),
    .second_value (second_value),
    .size_value   (size_value),
    .outcome      (outcome)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result <= outcome;
    end
  end

endmodule

[rtl/brp_checker.sv]
// ----------------------------------------------------------------------------
// Byte range parser checker
// Port-level checks on the item and result channels, bound to the top level.
// ----------------------------------------------------------------------------
module brp_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input brp_pkg::brp_in_t  item,
  input logic              result_valid,
  input logic              result_ready,
  input brp_pkg::brp_out_t result
);
  import brp_pkg::*;

  // An offered item stays put until its transfer happens.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid && $stable(item))
    else $error("item changed while waiting");

  // A stalled result transfer keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // Offsets are zero whenever the status is not a valid range.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.range_status != STATUS_VALID) |->
      (result.first_offset == '0) && (result.final_offset == '0))
    else $error("offsets set without a valid range");

  // A valid range never runs backwards.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.range_status == STATUS_VALID) |->
      result.first_offset <= result.final_offset)
    else $error("range start past range end");

  // Nothing is offered in the cycle after a reset cycle.
  assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result offered right after reset");

endmodule

bind http_byte_range_parser_unit brp_checker u_brp_checker (.*);
